/* hdl/dd_pkg.sv */
// Shared constants and types for the deadlock detector.
`timescale 1ns / 1ps

package dd_pkg;

  localparam int DEF_MAX_PROCS   = 16;
  localparam int DEF_MAX_RES     = 16;
  localparam int DEF_COUNT_WIDTH = 16;

  localparam int CFG_W = 5;

  localparam logic [1:0] REQ_ALLOC  = 2'd0;
  localparam logic [1:0] REQ_REQ    = 2'd1;
  localparam logic [1:0] REQ_AVAIL  = 2'd2;
  localparam logic [1:0] REQ_DETECT = 2'd3;

  localparam logic REG_NUM_PROCS = 1'b0;
  localparam logic REG_NUM_RES   = 1'b1;

  typedef struct packed {
    logic alloc_we;
    logic req_we;
    logic avail_we;
    logic work_we;
  } dd_we_t;

endpackage

/* hdl/dd_tables.sv */
// Allocation, request, available and work memories, registered read.
`timescale 1ns / 1ps

module dd_tables
  import dd_pkg::*;
#(
  parameter int MAX_PROCS   = DEF_MAX_PROCS,
  parameter int MAX_RES     = DEF_MAX_RES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  localparam int TAB_DEPTH  = MAX_PROCS * MAX_RES,
  localparam int AW = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1,
  localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1
) (
  input  logic                   clk,
  input  dd_we_t                 we,
  input  logic [AW-1:0]          tab_waddr,
  input  logic [RW-1:0]          avail_waddr,
  input  logic [COUNT_WIDTH-1:0] load_data,
  input  logic [AW-1:0]          tab_raddr,
  input  logic [RW-1:0]          col_raddr,
  input  logic [RW-1:0]          work_waddr,
  input  logic [COUNT_WIDTH-1:0] work_wdata,
  output logic [COUNT_WIDTH-1:0] alloc_q,
  output logic [COUNT_WIDTH-1:0] req_q,
  output logic [COUNT_WIDTH-1:0] avail_q,
  output logic [COUNT_WIDTH-1:0] work_q
);

  logic [COUNT_WIDTH-1:0] alloc_mem [TAB_DEPTH];
  logic [COUNT_WIDTH-1:0] req_mem   [TAB_DEPTH];
  logic [COUNT_WIDTH-1:0] avail_mem [MAX_RES];
  logic [COUNT_WIDTH-1:0] work_mem  [MAX_RES];

  always_ff @(posedge clk) begin
    if (we.alloc_we) begin
      alloc_mem[tab_waddr] <= load_data;
    end
    alloc_q <= alloc_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.req_we) begin
      req_mem[tab_waddr] <= load_data;
    end
    req_q <= req_mem[tab_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.avail_we) begin
      avail_mem[avail_waddr] <= load_data;
    end
    avail_q <= avail_mem[col_raddr];
  end

  always_ff @(posedge clk) begin
    if (we.work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_q <= work_mem[col_raddr];
  end

endmodule

/* hdl/deadlock_detector.sv */
// Deadlock detector top level: load sequencer and detection pass engine.
//
//   channel | dir | handshake            | payload
//   in_     | in  | in_tvalid/in_tready  | tuser req_type, tdata fields
//   out_    | out | out_tvalid/out_tready| tdata proc_id/flags, tlast last
//   cfg_    | in  | cfg_we               | cfg_index, cfg_wdata
//
// Load transactions are accepted back to back while idle. A detect transaction
// copies the available vector into the work memory, checks every process for
// a zero allocation, then runs passes: a finished process is skipped, an
// unfinished one gets a fit check and, when it fits, its allocation is added
// to work and it finishes; then np results follow. Columns go one per cycle
// through the single read port of the work memory. No clearing pass after reset:
// only the finished flags, the size registers and control are reset. A stalled
// out_tready holds the result sequence; the input stays blocked until the last result.
`timescale 1ns / 1ps

module deadlock_detector
  import dd_pkg::*;
#(
  parameter int MAX_PROCS   = DEF_MAX_PROCS,
  parameter int MAX_RES     = DEF_MAX_RES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [23:0]      in_tdata,   // proc_index[3:0], res_index[7:4], value[23:8]
  input  logic [1:0]       in_tuser,   // req_type[1:0]
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // proc_id[3:0], deadlocked[4], any_deadlock[5], zero
  output logic             out_tlast,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int TAB_DEPTH = MAX_PROCS * MAX_RES;
  localparam int AW = (TAB_DEPTH > 1) ? $clog2(TAB_DEPTH) : 1;
  localparam int RW = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = COUNT_WIDTH;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_COPY = 3'd1;
  localparam logic [2:0] S_ZCHK = 3'd2;
  localparam logic [2:0] S_PSEL = 3'd3;
  localparam logic [2:0] S_FIT  = 3'd4;
  localparam logic [2:0] S_ADD  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  logic [2:0]           state_r, state_nxt;
  logic [CFG_W-1:0]     num_procs_r, num_res_r;
  logic [RW-1:0]        col_r, col_nxt, cold_r, cold_nxt;
  logic                 iss_r, iss_nxt, vld_r, vld_nxt, lastd_r, lastd_nxt;
  logic [PW-1:0]        p_r, p_nxt;
  logic                 acc_r, acc_nxt, prog_r, prog_nxt, any_r, any_nxt;
  logic [MAX_PROCS-1:0] fin_r, fin_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [3:0]           out_id_r, out_id_nxt;
  logic                 out_dl_r, out_dl_nxt, out_any_r, out_any_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [PW-1:0]        np_last;
  logic [RW-1:0]        nr_last;
  int                   np_cl, nr_cl;
  logic                 in_acc, scan_done, scan_start, adv, adv_prog;
  logic                 nz_now, fail_now, proc_ok, res_ok;
  logic [3:0]           in_proc, in_res;
  logic [CW:0]          sum;
  logic [CW-1:0]        sat, work_wdata;
  logic                 work_we;
  dd_we_t               we;
  logic [CW-1:0]        alloc_q, req_q, avail_q, work_q;

  assign in_proc = in_tdata[3:0];
  assign in_res  = in_tdata[7:4];

  always_comb begin
    if (num_procs_r == '0) np_cl = 1;
    else if (int'(num_procs_r) > MAX_PROCS) np_cl = MAX_PROCS;
    else np_cl = int'(num_procs_r);
    if (num_res_r == '0) nr_cl = 1;
    else if (int'(num_res_r) > MAX_RES) nr_cl = MAX_RES;
    else nr_cl = int'(num_res_r);
  end

  assign np_last = PW'(np_cl - 1);
  assign nr_last = RW'(nr_cl - 1);

  assign in_tready = rst_n && (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign proc_ok   = 32'(in_proc) < MAX_PROCS;
  assign res_ok    = 32'(in_res) < MAX_RES;

  assign we.alloc_we = in_acc && (in_tuser == REQ_ALLOC) && proc_ok && res_ok;
  assign we.req_we   = in_acc && (in_tuser == REQ_REQ) && proc_ok && res_ok;
  assign we.avail_we = in_acc && (in_tuser == REQ_AVAIL) && res_ok;
  assign we.work_we  = work_we;

  assign scan_done = vld_r && lastd_r;
  assign nz_now    = acc_r || (alloc_q != '0);
  assign fail_now  = acc_r || (req_q > work_q);
  assign sum       = {1'b0, work_q} + {1'b0, alloc_q};
  assign sat       = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];

  dd_tables #(
    .MAX_PROCS  (MAX_PROCS),
    .MAX_RES    (MAX_RES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tables (
    .clk        (clk),
    .we         (we),
    .tab_waddr  (AW'(32'(in_proc) * MAX_RES + 32'(in_res))),
    .avail_waddr(RW'(in_res)),
    .load_data  (CW'(in_tdata[23:8])),
    .tab_raddr  (AW'(32'(p_r) * MAX_RES + 32'(col_r))),
    .col_raddr  (col_r),
    .work_waddr (cold_r),
    .work_wdata (work_wdata),
    .alloc_q    (alloc_q),
    .req_q      (req_q),
    .avail_q    (avail_q),
    .work_q     (work_q)
  );

  always_comb begin
    state_nxt      = state_r;
    col_nxt        = col_r;
    iss_nxt        = iss_r;
    vld_nxt        = 1'b0;
    lastd_nxt      = lastd_r;
    cold_nxt       = cold_r;
    p_nxt          = p_r;
    acc_nxt        = acc_r;
    prog_nxt       = prog_r;
    fin_nxt        = fin_r;
    any_nxt        = any_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_id_nxt     = out_id_r;
    out_dl_nxt     = out_dl_r;
    out_any_nxt    = out_any_r;
    out_last_nxt   = out_last_r;
    adv            = 1'b0;
    adv_prog       = prog_r;
    scan_start     = 1'b0;
    work_we        = 1'b0;
    work_wdata     = avail_q;

    // column issue: read at col_r, data lands in the next cycle with its column in cold_r
    if (iss_r) begin
      vld_nxt   = 1'b1;
      cold_nxt  = col_r;
      lastd_nxt = (col_r == nr_last);
      if (col_r == nr_last) iss_nxt = 1'b0;
      else col_nxt = col_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_tuser == REQ_DETECT)) begin
          state_nxt  = S_COPY;
          scan_start = 1'b1;
        end
      end
      S_COPY: begin
        work_we = vld_r;
        if (scan_done) begin
          state_nxt  = S_ZCHK;
          p_nxt      = '0;
          scan_start = 1'b1;
        end
      end
      S_ZCHK: begin
        if (vld_r) acc_nxt = nz_now;
        if (scan_done) begin
          fin_nxt[p_r] = !nz_now;
          if (p_r == np_last) begin
            state_nxt = S_PSEL;
            p_nxt     = '0;
            prog_nxt  = 1'b0;
          end else begin
            p_nxt      = p_r + 1'b1;
            scan_start = 1'b1;
          end
        end
      end
      S_PSEL: begin
        if (fin_r[p_r]) begin
          adv = 1'b1;
        end else begin
          state_nxt  = S_FIT;
          scan_start = 1'b1;
        end
      end
      S_FIT: begin
        if (vld_r) acc_nxt = fail_now;
        if (scan_done) begin
          if (fail_now) begin
            adv = 1'b1;
          end else begin
            state_nxt  = S_ADD;
            scan_start = 1'b1;
          end
        end
      end
      S_ADD: begin
        work_we    = vld_r;
        work_wdata = sat;
        if (scan_done) begin
          fin_nxt[p_r] = 1'b1;
          adv          = 1'b1;
          adv_prog     = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_id_nxt     = 4'(p_r);
          out_dl_nxt     = !fin_r[p_r];
          out_last_nxt   = (p_r == np_last);
          out_any_nxt    = (p_r == np_last) && (any_r || !fin_r[p_r]);
          any_nxt        = any_r || !fin_r[p_r];
          if (p_r == np_last) state_nxt = S_IDLE;
          else p_nxt = p_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // next process of the pass, a new pass, or the result phase
    if (adv) begin
      if (p_r == np_last) begin
        p_nxt = '0;
        if (adv_prog) begin
          state_nxt = S_PSEL;
          prog_nxt  = 1'b0;
        end else begin
          state_nxt = S_EMIT;
          any_nxt   = 1'b0;
        end
      end else begin
        p_nxt     = p_r + 1'b1;
        state_nxt = S_PSEL;
        prog_nxt  = adv_prog;
      end
    end

    if (scan_start) begin
      col_nxt = '0;
      iss_nxt = 1'b1;
      vld_nxt = 1'b0;
      acc_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_procs_r  <= CFG_W'(16);
      num_res_r    <= CFG_W'(16);
      iss_r        <= 1'b0;
      vld_r        <= 1'b0;
      fin_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_r        <= iss_nxt;
      vld_r        <= vld_nxt;
      fin_r        <= fin_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_we) begin
        if (cfg_index == REG_NUM_PROCS) num_procs_r <= cfg_wdata;
        else num_res_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r      <= col_nxt;
    cold_r     <= cold_nxt;
    lastd_r    <= lastd_nxt;
    p_r        <= p_nxt;
    acc_r      <= acc_nxt;
    prog_r     <= prog_nxt;
    any_r      <= any_nxt;
    out_id_r   <= out_id_nxt;
    out_dl_r   <= out_dl_nxt;
    out_any_r  <= out_any_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_any_r, out_dl_r, out_id_r};
  assign out_tlast  = out_last_r;

endmodule

/* hdl/dd_chk.sv */
// Port-level assertion checker for the deadlock detector, bound to the top.
`timescale 1ns / 1ps

module dd_chk
  import dd_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_detect_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == REQ_DETECT) |=> !in_tready)
    else $error("input open right after detect transaction");

  a_mid_run_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open while results pending");

  a_any_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !out_tdata[5])
    else $error("any_deadlock set before last result");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind deadlock_detector dd_chk u_dd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast)
);

/* tb/tb.sv */
// Self-checking testbench for deadlock_detector: stream driver, result checker, predictor.
`timescale 1ns / 1ps

module tb;
  import dd_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  proc;
    logic [3:0]  res;
    logic [15:0] value;
  } cmd_t;

  typedef struct packed {
    logic       last;
    logic       any_deadlock;
    logic       deadlocked;
    logic [3:0] proc_id;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [4:0]  cfg_wdata = '0;

  // predictor state
  logic [15:0] alloc_cnt [16][16];
  logic [15:0] need_cnt [16][16];
  logic [15:0] avail_cnt [16];
  logic [4:0]  raw_procs = 5'd16;
  logic [4:0]  raw_res = 5'd16;

  // which entries the stimulus has written
  logic set_alloc [16][16];
  logic set_need [16][16];
  logic set_avail [16];

  cmd_t     cmd_q [$];
  verdict_t verdict_q [$];
  cmd_t     drv_cmd;

  int  n_queued = 0, n_accepted = 0, n_checked = 0, n_errors = 0;
  int  n_detects = 0, n_dl_detects = 0;
  int  in_gap = 0, in_quiet = 0, out_stall = 0, out_quiet = 0;
  logic calm = 1'b0;

  deadlock_detector u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic int clamp_size(logic [4:0] raw);
    if (raw == 5'd0) return 1;
    if (raw > 5'd16) return 16;
    return int'(raw);
  endfunction

  function automatic void find_deadlocks();
    int np, nr;
    logic [15:0] work [16];
    logic done [16];
    logic moved, any_dl, fits, zero;
    logic [16:0] sum;
    verdict_t v;
    np = clamp_size(raw_procs);
    nr = clamp_size(raw_res);
    for (int r = 0; r < nr; r++) work[r] = avail_cnt[r];
    for (int p = 0; p < np; p++) begin
      zero = 1'b1;
      for (int r = 0; r < nr; r++) if (alloc_cnt[p][r] != 16'd0) zero = 1'b0;
      done[p] = zero;
    end
    moved = 1'b1;
    while (moved) begin
      moved = 1'b0;
      for (int p = 0; p < np; p++) begin
        if (!done[p]) begin
          fits = 1'b1;
          for (int r = 0; r < nr; r++) if (need_cnt[p][r] > work[r]) fits = 1'b0;
          if (fits) begin
            for (int r = 0; r < nr; r++) begin
              sum = {1'b0, work[r]} + {1'b0, alloc_cnt[p][r]};
              work[r] = sum[16] ? 16'hFFFF : sum[15:0];
            end
            done[p] = 1'b1;
            moved = 1'b1;
          end
        end
      end
    end
    any_dl = 1'b0;
    for (int p = 0; p < np; p++) if (!done[p]) any_dl = 1'b1;
    n_detects++;
    if (any_dl) n_dl_detects++;
    for (int p = 0; p < np; p++) begin
      v.proc_id      = 4'(p);
      v.deadlocked   = !done[p];
      v.last         = (p == np - 1);
      v.any_deadlock = v.last && any_dl;
      verdict_q.push_back(v);
    end
  endfunction

  // predictor: update tables, or run a detection, on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      n_accepted++;
      case (in_tuser)
        REQ_ALLOC: alloc_cnt[in_tdata[3:0]][in_tdata[7:4]] = in_tdata[23:8];
        REQ_REQ:   need_cnt[in_tdata[3:0]][in_tdata[7:4]] = in_tdata[23:8];
        REQ_AVAIL: avail_cnt[in_tdata[7:4]] = in_tdata[23:8];
        default:   find_deadlocks();
      endcase
    end
  end

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        drv_cmd = cmd_q.pop_front();
        in_tuser <= drv_cmd.kind;
        in_tdata <= {drv_cmd.value, drv_cmd.res, drv_cmd.proc};
        in_tvalid <= 1'b1;
        if (in_quiet > 0) in_quiet--;
        else if (!calm && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 12);
          in_quiet = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : 0;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  function automatic void flag_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    n_errors++;
  endfunction

  function automatic void check_result();
    verdict_t v;
    if (verdict_q.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual tdata %h tlast %b",
               $time, out_tdata, out_tlast);
      n_errors++;
      return;
    end
    v = verdict_q.pop_front();
    n_checked++;
    if (out_tdata[3:0] !== v.proc_id) flag_field("proc_id", v.proc_id, out_tdata[3:0]);
    if (out_tdata[4] !== v.deadlocked)
      flag_field("deadlocked", 4'(v.deadlocked), 4'(out_tdata[4]));
    if (out_tdata[5] !== v.any_deadlock)
      flag_field("any_deadlock", 4'(v.any_deadlock), 4'(out_tdata[5]));
    if (out_tlast !== v.last) flag_field("last", 4'(v.last), 4'(out_tlast));
    if (out_tdata[7:6] !== 2'b00) flag_field("tdata pad", 4'd0, 4'(out_tdata[7:6]));
  endfunction

  // monitor and result-side backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_result();
      if (calm) begin
        out_tready <= 1'b1;
      end else if (out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (out_quiet > 0) out_quiet--;
        else if ($urandom_range(0, 7) == 0) begin
          out_stall = $urandom_range(1, 12);
          out_quiet = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60) : 0;
        end
      end
    end
  end

  function automatic void push_item(logic [1:0] kind, logic [3:0] p, logic [3:0] r,
                                    logic [15:0] val);
    cmd_t c;
    c.kind  = kind;
    c.proc  = p;
    c.res   = r;
    c.value = val;
    cmd_q.push_back(c);
    n_queued++;
    case (kind)
      REQ_ALLOC: set_alloc[p][r] = 1'b1;
      REQ_REQ:   set_need[p][r] = 1'b1;
      REQ_AVAIL: set_avail[r] = 1'b1;
      default: ;
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 4));
      6, 7:             return 16'($urandom);
      8:                return 16'hFFFF;
      default:          return 16'($urandom_range(0, 1));
    endcase
  endfunction

  // every entry a detection reads must have been written
  function automatic void fill_missing();
    int np, nr;
    np = clamp_size(raw_procs);
    nr = clamp_size(raw_res);
    for (int r = 0; r < nr; r++)
      if (!set_avail[r]) push_item(REQ_AVAIL, 4'($urandom), 4'(r), pick_count());
    for (int p = 0; p < np; p++)
      for (int r = 0; r < nr; r++) begin
        if (!set_alloc[p][r]) push_item(REQ_ALLOC, 4'(p), 4'(r), pick_count());
        if (!set_need[p][r]) push_item(REQ_REQ, 4'(p), 4'(r), pick_count());
      end
  endfunction

  function automatic void push_detect();
    fill_missing();
    push_item(REQ_DETECT, 4'($urandom), 4'($urandom), 16'($urandom));
  endfunction

  function automatic void run_scenario();
    int np, nr;
    np = clamp_size(raw_procs);
    nr = clamp_size(raw_res);
    if ($urandom_range(0, 3) != 0) begin
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 2))
          0: push_item(REQ_ALLOC, 4'($urandom_range(0, np - 1)),
                       4'($urandom_range(0, nr - 1)), pick_count());
          1: push_item(REQ_REQ, 4'($urandom_range(0, np - 1)),
                       4'($urandom_range(0, nr - 1)), pick_count());
          default: push_item(REQ_AVAIL, 4'($urandom), 4'($urandom_range(0, nr - 1)),
                             pick_count());
        endcase
      end
      push_detect();
    end else begin
      // stray writes anywhere in the tables, sometimes without a detection
      repeat ($urandom_range(1, 5))
        push_item(2'($urandom_range(0, 2)), 4'($urandom), 4'($urandom), 16'($urandom));
      if ($urandom_range(0, 1) == 1) push_detect();
    end
  endfunction

  task automatic set_cfg(input logic idx, input logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_NUM_PROCS) raw_procs = val;
    else raw_res = val;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || verdict_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    logic [4:0] procs_plan [7];
    logic [4:0] res_plan [7];
    int start;
    procs_plan = '{5'd1, 5'd31, 5'd0, 5'd5, 5'd2, 5'd8, 5'd16};
    res_plan   = '{5'd16, 5'd1, 5'd0, 5'd4, 5'd7, 5'd3, 5'd2};
    for (int p = 0; p < 16; p++) begin
      set_avail[p] = 1'b0;
      for (int r = 0; r < 16; r++) begin
        set_alloc[p][r] = 1'b0;
        set_need[p][r] = 1'b0;
      end
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    set_cfg(REG_NUM_PROCS, 5'd3);
    set_cfg(REG_NUM_RES, 5'd2);
    // p0 idle, p1 fits and saturates work, p2 blocked on column 1
    push_item(REQ_AVAIL, 4'd0, 4'd0, 16'hFFFF);
    push_item(REQ_AVAIL, 4'd0, 4'd1, 16'd0);
    push_item(REQ_ALLOC, 4'd0, 4'd0, 16'd0);
    push_item(REQ_ALLOC, 4'd0, 4'd1, 16'd0);
    push_item(REQ_REQ, 4'd0, 4'd0, 16'hFFFF);
    push_item(REQ_REQ, 4'd0, 4'd1, 16'hFFFF);
    push_item(REQ_ALLOC, 4'd1, 4'd0, 16'd5);
    push_item(REQ_ALLOC, 4'd1, 4'd1, 16'd1);
    push_item(REQ_REQ, 4'd1, 4'd0, 16'hFFFF);
    push_item(REQ_REQ, 4'd1, 4'd1, 16'd0);
    push_item(REQ_ALLOC, 4'd2, 4'd0, 16'd3);
    push_item(REQ_ALLOC, 4'd2, 4'd1, 16'd0);
    push_item(REQ_REQ, 4'd2, 4'd0, 16'd0);
    push_item(REQ_REQ, 4'd2, 4'd1, 16'd2);
    push_item(REQ_DETECT, 4'd0, 4'd0, 16'd0);
    push_item(REQ_REQ, 4'd2, 4'd1, 16'd1);
    push_item(REQ_DETECT, 4'hF, 4'hF, 16'hFFFF);
    // p1 can only go after p2 releases, which needs a second pass
    push_item(REQ_ALLOC, 4'd2, 4'd1, 16'd1);
    push_item(REQ_REQ, 4'd2, 4'd1, 16'd0);
    push_item(REQ_REQ, 4'd1, 4'd1, 16'd1);
    push_item(REQ_ALLOC, 4'hF, 4'hF, 16'hFFFF);
    push_item(REQ_REQ, 4'hF, 4'hF, 16'd0);
    push_item(REQ_DETECT, 4'd0, 4'd0, 16'd0);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 6) calm = 1'b1;
      set_cfg(REG_NUM_PROCS, procs_plan[ph]);
      set_cfg(REG_NUM_RES, res_plan[ph]);
      start = n_queued;
      while (n_queued - start < 20) run_scenario();
      push_detect();
      drain();
    end

    $display("Sent %0d input transactions across 8 table sizes; %0d detections ran,",
             n_accepted, n_detects);
    $display("%0d of them found a deadlock; %0d results checked.", n_dl_detects, n_checked);
    if (n_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout waiting for results");
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
hdl/dd_pkg.sv
hdl/dd_tables.sv
hdl/deadlock_detector.sv
hdl/dd_chk.sv
tb/tb.sv
